FILE: rtl/core/bmmd_pkg.sv
// Package with the memory map constants, codes and helpers of the bus decoder.
`default_nettype none

package bmmd_pkg;

	// Default bank counts.
	localparam int unsigned CART_ROM_BANKS_DEF = 4;
	localparam int unsigned SRAM_BANKS_DEF     = 4;
	localparam int unsigned WRAM_BANKS_DEF     = 2;

	// Sizes of the regions in the unified store.
	localparam int unsigned ROM_BANK_SIZE  = 16384;
	localparam int unsigned BOOT_SIZE      = 256;
	localparam int unsigned VRAM_SIZE      = 8192;
	localparam int unsigned SRAM_BANK_SIZE = 8192;
	localparam int unsigned WRAM_BANK_SIZE = 4096;
	localparam int unsigned OAM_SIZE       = 160;
	localparam int unsigned HRAM_SIZE      = 127;

	// Bus addresses that bound the regions.
	localparam logic [15:0] ADDR_BOOT_END  = 16'h00FF;
	localparam logic [15:0] ADDR_ECHO_END  = 16'hFDFF;
	localparam logic [15:0] ADDR_OAM_END   = 16'hFE9F;
	localparam logic [15:0] ADDR_UNUSED_END = 16'hFEFF;
	localparam logic [15:0] ADDR_IO_END    = 16'hFF7F;
	localparam logic [15:0] ADDR_HRAM_BASE = 16'hFF80;
	localparam logic [15:0] ADDR_HRAM_END  = 16'hFFFE;
	localparam logic [15:0] ADDR_IRQ_EN    = 16'hFFFF;
	localparam logic [15:0] ADDR_ROM_END   = 16'h7FFF;
	localparam logic [15:0] ADDR_FIXED_END = 16'h3FFF;

	localparam logic [7:0] JOYP_MASK  = 8'b00110000;
	localparam logic [7:0] STAT_MASK  = 8'b01111000;
	localparam logic [7:0] OPEN_BUS   = 8'hFF;

	localparam int unsigned BANK_CNT_W = 11;

	typedef enum logic [1:0] {
		OP_READ      = 2'd0,
		OP_WRITE     = 2'd1,
		OP_LOAD_CART = 2'd2,
		OP_LOAD_BOOT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_BOOT_EN   = 2'd0,
		CFG_ROM_BANK  = 2'd1,
		CFG_SRAM_BANK = 2'd2,
		CFG_WRAM_BANK = 2'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		IO_JOYP,
		IO_DIV,
		IO_TIMA,
		IO_TMA,
		IO_TAC,
		IO_IF,
		IO_LCDC,
		IO_STAT,
		IO_SCY,
		IO_SCX,
		IO_LY,
		IO_LYC,
		IO_BGP,
		IO_OBP0,
		IO_OBP1,
		IO_WY,
		IO_WX,
		IO_IE,
		IO_NONE
	} io_idx_t;

	localparam int unsigned IO_COUNT = 18;

	// Maps the low seven address bits of the I/O page to a register.
	function automatic io_idx_t io_index(input logic [6:0] lo);
		io_idx_t r;
		case (lo)
			7'h00: r = IO_JOYP;
			7'h04: r = IO_DIV;
			7'h05: r = IO_TIMA;
			7'h06: r = IO_TMA;
			7'h07: r = IO_TAC;
			7'h0F: r = IO_IF;
			7'h40: r = IO_LCDC;
			7'h41: r = IO_STAT;
			7'h42: r = IO_SCY;
			7'h43: r = IO_SCX;
			7'h44: r = IO_LY;
			7'h45: r = IO_LYC;
			7'h47: r = IO_BGP;
			7'h48: r = IO_OBP0;
			7'h49: r = IO_OBP1;
			7'h4A: r = IO_WY;
			7'h4B: r = IO_WX;
			default: r = IO_NONE;
		endcase
		return r;
	endfunction

	// Wraps a small bank number into the bank count with two compare and subtract steps.
	function automatic logic [1:0] bank_wrap(input logic [1:0] v, input int unsigned n);
		logic [BANK_CNT_W-1:0] r;
		r = BANK_CNT_W'(v);
		if (r >= BANK_CNT_W'(2 * n)) r = r - BANK_CNT_W'(2 * n);
		if (r >= BANK_CNT_W'(n)) r = r - BANK_CNT_W'(n);
		return r[1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/banked_memory_map_bus_decoder.sv
// Banked memory map bus decoder: unified byte store, I/O register file and read pipeline.
// A read passes through stage one and the output register before its byte shows at the output.
// One transaction per cycle is accepted unless stage one holds a read behind a stalled output.
// The single-port store takes one access per cycle and sets that rate.
// Reset clears the I/O registers and the pipeline and returns the bank selects to their defaults.
// The store is not cleared; a store entry is only defined once it has been written or preloaded.
`default_nettype none

module banked_memory_map_bus_decoder
	import bmmd_pkg::*;
#(
	parameter int unsigned CART_ROM_BANKS = CART_ROM_BANKS_DEF,
	parameter int unsigned SRAM_BANKS     = SRAM_BANKS_DEF,
	parameter int unsigned WRAM_BANKS     = WRAM_BANKS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  write_data,
	input  wire logic [1:0]  load_bank,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       read_data,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [1:0]  cfg_data
);

	// The whole address space of ROM and RAM lives in one store, one region after another.
	localparam int unsigned CART_BASE = 0;
	localparam int unsigned BOOT_BASE = CART_BASE + CART_ROM_BANKS * ROM_BANK_SIZE;
	localparam int unsigned VRAM_BASE = BOOT_BASE + BOOT_SIZE;
	localparam int unsigned SRAM_BASE = VRAM_BASE + VRAM_SIZE;
	localparam int unsigned WRAM_BASE = SRAM_BASE + SRAM_BANKS * SRAM_BANK_SIZE;
	localparam int unsigned OAM_BASE  = WRAM_BASE + WRAM_BANKS * WRAM_BANK_SIZE;
	localparam int unsigned HRAM_BASE = OAM_BASE + OAM_SIZE;
	localparam int unsigned MEM_DEPTH = HRAM_BASE + HRAM_SIZE;
	localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

	// Bank selects; the user must write them only while the decoder is idle, which the block itself does not enforce.
	logic       boot_en_q;
	logic [1:0] rom_bank_q;
	logic [1:0] sram_bank_q;
	logic       wram_bank_q;

	// I/O register file.
	logic [7:0] io_q [IO_COUNT];

	// Unified byte store.
	logic [7:0] store_q [MEM_DEPTH];

	// Read pipeline: stage one holds the store read, the output register holds the result.
	logic       valid_s1;
	logic       from_mem_s1;
	logic [7:0] rd_data_s1;
	logic [7:0] io_data_s1;
	logic       out_valid_q;
	logic [7:0] read_data_q;

	logic              take;
	logic              adv_s1;
	logic              is_read;
	logic [1:0]        rom_bank;
	logic [1:0]        sram_bank;
	logic              wram_bank;
	logic [1:0]        cart_bank;
	logic              ram_hit;
	logic [MEM_AW-1:0] ram_addr;
	logic [MEM_AW-1:0] mem_addr;
	logic              mem_rd;
	logic              mem_wr;
	io_idx_t           io_sel;
	logic              io_wr;
	logic [7:0]        io_rd_data;

	// Configuration transactions are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_en_q   <= 1'b1;
			rom_bank_q  <= 2'd1;
			sram_bank_q <= 2'd0;
			wram_bank_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BOOT_EN:   boot_en_q   <= cfg_data[0];
				CFG_ROM_BANK:  rom_bank_q  <= cfg_data;
				CFG_SRAM_BANK: sram_bank_q <= cfg_data;
				CFG_WRAM_BANK: wram_bank_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Bank numbers are taken modulo the bank count of each region.
	assign rom_bank  = bank_wrap(rom_bank_q, CART_ROM_BANKS);
	assign sram_bank = bank_wrap(sram_bank_q, SRAM_BANKS);
	assign wram_bank = bank_wrap({1'b0, wram_bank_q}, WRAM_BANKS) != 2'd0;
	assign cart_bank = bank_wrap(load_bank, CART_ROM_BANKS);

	// Handshake. A new transaction enters when stage one is empty or moves on this cycle.
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign take     = in_valid && in_ready;
	assign is_read  = op_t'(operation) == OP_READ;

	// RAM decode for the upper half of the bus: video, static, work RAM with its echo,
	// OAM and high RAM. The unusable range, the I/O page and the interrupt enable miss.
	always_comb begin
		ram_hit  = 1'b1;
		ram_addr = '0;
		case (address[15:12])
			4'h8, 4'h9: ram_addr = MEM_AW'(VRAM_BASE) + MEM_AW'(address[12:0]);
			4'hA, 4'hB: ram_addr = MEM_AW'(SRAM_BASE) + MEM_AW'({sram_bank, address[12:0]});
			4'hC, 4'hE: ram_addr = MEM_AW'(WRAM_BASE) + MEM_AW'(address[11:0]);
			4'hD: ram_addr = MEM_AW'(WRAM_BASE) + MEM_AW'({wram_bank, address[11:0]});
			4'hF: begin
				if (address <= ADDR_ECHO_END) begin
					ram_addr = MEM_AW'(WRAM_BASE) + MEM_AW'({wram_bank, address[11:0]});
				end else if (address <= ADDR_OAM_END) begin
					ram_addr = MEM_AW'(OAM_BASE) + MEM_AW'(address[7:0]);
				end else if (address >= ADDR_HRAM_BASE && address <= ADDR_HRAM_END) begin
					ram_addr = MEM_AW'(HRAM_BASE) + MEM_AW'(address[6:0]);
				end else begin
					ram_hit = 1'b0;
				end
			end
			default: ram_hit = 1'b0;
		endcase
	end

	// I/O decode: the interrupt enable sits apart from the rest of the register page.
	always_comb begin
		io_sel = IO_NONE;
		if (address == ADDR_IRQ_EN) begin
			io_sel = IO_IE;
		end else if (address > ADDR_UNUSED_END && address <= ADDR_IO_END) begin
			io_sel = io_index(address[6:0]);
		end
	end

	// Unmapped I/O, the serial port and the unusable range read as an open bus.
	always_comb begin
		io_rd_data = OPEN_BUS;
		if (io_sel != IO_NONE) io_rd_data = io_q[io_sel];
	end

	// Access decode for one transaction.
	always_comb begin
		mem_addr = ram_addr;
		mem_rd   = 1'b0;
		mem_wr   = 1'b0;
		io_wr    = 1'b0;
		case (op_t'(operation))
			OP_READ: begin
				if (address <= ADDR_FIXED_END) begin
					mem_rd = 1'b1;
					if (boot_en_q && address <= ADDR_BOOT_END) begin
						mem_addr = MEM_AW'(BOOT_BASE) + MEM_AW'(address[7:0]);
					end else begin
						mem_addr = MEM_AW'(CART_BASE) + MEM_AW'(address[13:0]);
					end
				end else if (address <= ADDR_ROM_END) begin
					mem_rd   = 1'b1;
					mem_addr = MEM_AW'(CART_BASE) + MEM_AW'({rom_bank, address[13:0]});
				end else begin
					mem_rd = ram_hit;
				end
			end
			OP_WRITE: begin
				// The ROM area has no bank controller, so writes there are dropped.
				if (address > ADDR_ROM_END) begin
					mem_wr = ram_hit;
					io_wr  = !ram_hit && io_sel != IO_NONE;
				end
			end
			OP_LOAD_CART: begin
				mem_wr   = 1'b1;
				mem_addr = MEM_AW'(CART_BASE) + MEM_AW'({cart_bank, address[13:0]});
			end
			OP_LOAD_BOOT: begin
				mem_wr   = 1'b1;
				mem_addr = MEM_AW'(BOOT_BASE) + MEM_AW'(address[7:0]);
			end
			default: ;
		endcase
	end

	// Store port. A read in the cycle after a write to the same entry sees the new byte.
	always_ff @(posedge clk) begin
		if (take && mem_wr) store_q[mem_addr] <= write_data;
		if (take && mem_rd) rd_data_s1 <= store_q[mem_addr];
	end

	// I/O register file. The joypad and status registers keep their fixed bits, and
	// any write to the divider clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < IO_COUNT; i++) io_q[i] <= '0;
		end else if (take && io_wr) begin
			case (io_sel)
				IO_JOYP: io_q[IO_JOYP] <= (io_q[IO_JOYP] & ~JOYP_MASK) | (write_data & JOYP_MASK);
				IO_STAT: io_q[IO_STAT] <= (io_q[IO_STAT] & ~STAT_MASK) | (write_data & STAT_MASK);
				IO_DIV:  io_q[IO_DIV]  <= '0;
				default: io_q[io_sel]  <= write_data;
			endcase
		end
	end

	// Stage one payload that does not come from the store.
	always_ff @(posedge clk) begin
		if (take && is_read) begin
			from_mem_s1 <= mem_rd;
			io_data_s1  <= io_rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take && is_read) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) read_data_q <= from_mem_s1 ? rd_data_s1 : io_data_s1;
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

endmodule

`default_nettype wire

FILE: verif/banked_memory_map_bus_decoder_tb.sv
// Self-checking testbench for the banked memory map bus decoder.
`default_nettype none

module banked_memory_map_bus_decoder_tb;
	import bmmd_pkg::*;

	// The mirror keeps every byte store of the block in one flat array. Each region
	// starts at its own base cell, laid out in the order of the package sizes.
	localparam int CART_CELL0  = 0;
	localparam int BOOT_CELL0  = CART_CELL0 + CART_ROM_BANKS_DEF * ROM_BANK_SIZE;
	localparam int VRAM_CELL0  = BOOT_CELL0 + BOOT_SIZE;
	localparam int SRAM_CELL0  = VRAM_CELL0 + VRAM_SIZE;
	localparam int WRAM_CELL0  = SRAM_CELL0 + SRAM_BANKS_DEF * SRAM_BANK_SIZE;
	localparam int OAM_CELL0   = WRAM_CELL0 + WRAM_BANKS_DEF * WRAM_BANK_SIZE;
	localparam int HRAM_CELL0  = OAM_CELL0 + OAM_SIZE;
	localparam int STORE_DEPTH = HRAM_CELL0 + HRAM_SIZE;

	// Bus addresses that the stimulus aims at by name.
	localparam logic [15:0] VRAM_BASE_ADDR   = 16'h8000;
	localparam logic [15:0] OAM_BASE_ADDR    = 16'hFE00;
	localparam logic [15:0] UNUSED_BASE_ADDR = 16'hFEA0;
	localparam logic [15:0] IO_BASE_ADDR     = 16'hFF00;
	localparam logic [15:0] JOYPAD_ADDR      = 16'hFF00;
	localparam logic [15:0] SERIAL_DATA_ADDR = 16'hFF01;
	localparam logic [15:0] SERIAL_CTRL_ADDR = 16'hFF02;
	localparam logic [15:0] DIVIDER_ADDR     = 16'hFF04;
	localparam logic [15:0] STATUS_ADDR      = 16'hFF41;
	localparam logic [15:0] WRAM_HIGH_ADDR   = 16'hDDFF;

	// Offsets within the I/O page that hold a register; every other offset reads open bus.
	localparam logic [6:0] IO_OFFSETS [17] = '{
		7'h00, 7'h04, 7'h05, 7'h06, 7'h07, 7'h0F, 7'h40, 7'h41, 7'h42,
		7'h43, 7'h44, 7'h45, 7'h47, 7'h48, 7'h49, 7'h4A, 7'h4B
	};

	// A read comes back through stage one and the output register, and these pauses give
	// the last write time to land before a bank select changes or the run ends.
	localparam int SETTLE_CYCLES  = 6;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int IDLE_PERCENT   = 19;
	localparam int KNOWN_DEPTH    = 512;
	localparam int PHASE_ITEMS    = 110;

	typedef struct {
		logic [15:0] addr;
		logic [7:0]  value;
	} pending_read_t;

	// Every input starts at a known value before the first clock edge.
	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [1:0]  operation  = OP_READ;
	logic [15:0] address    = 16'h0000;
	logic [7:0]  write_data = 8'h00;
	logic [1:0]  load_bank  = 2'd0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [7:0]  read_data;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index  = CFG_BOOT_EN;
	logic [1:0]  cfg_data   = 2'd0;

	// While set, neither the sender nor the receiver inserts any idle cycle.
	bit steady = 1'b0;
	int mismatch_count = 0;
	int stall_cycles = 0;

	// Mirror of the decoder: bank selects, byte stores, I/O page and interrupt enable.
	logic       boot_en  = 1'b1;
	logic [1:0] rom_sel  = 2'd1;
	logic [1:0] sram_sel = 2'd0;
	logic       wram_sel = 1'b1;
	logic [7:0] mirror_mem [STORE_DEPTH];
	bit         mirror_written [STORE_DEPTH];
	logic [7:0] io_regs [128];
	logic [7:0] irq_enable = 8'h00;

	// Reads accepted by the block whose data has not come back yet, oldest first.
	pending_read_t pending_reads [$];
	pending_read_t head_read;

	// Bus addresses that were written or preloaded; reads are drawn from here so that
	// no store entry is read before it holds a value.
	logic [15:0] known_addrs [$];

	always #2 clk = ~clk;

	banked_memory_map_bus_decoder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.address    (address),
		.write_data (write_data),
		.load_bank  (load_bank),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic bit io_mapped(input logic [6:0] lo);
		foreach (IO_OFFSETS[k]) begin
			if (IO_OFFSETS[k] == lo) return 1'b1;
		end
		return 1'b0;
	endfunction

	// Resolves a bus address to the mirror cell that a read of it returns, or -1 when
	// the address is an I/O register, the interrupt enable or the unusable range.
	function automatic int cell_of(input logic [15:0] a);
		int sb;
		int wb;
		sb = int'(sram_sel) % SRAM_BANKS_DEF;
		wb = int'(wram_sel) % WRAM_BANKS_DEF;
		if (a <= ADDR_FIXED_END) begin
			if (boot_en && a <= ADDR_BOOT_END) return BOOT_CELL0 + int'(a[7:0]);
			return CART_CELL0 + int'(a[13:0]);
		end
		if (a <= ADDR_ROM_END)
			return CART_CELL0 + (int'(rom_sel) % CART_ROM_BANKS_DEF) * ROM_BANK_SIZE
				+ int'(a[13:0]);
		case (a[15:12])
			4'h8, 4'h9: return VRAM_CELL0 + int'(a[12:0]);
			4'hA, 4'hB: return SRAM_CELL0 + sb * SRAM_BANK_SIZE + int'(a[12:0]);
			4'hC, 4'hE: return WRAM_CELL0 + int'(a[11:0]);
			4'hD: return WRAM_CELL0 + wb * WRAM_BANK_SIZE + int'(a[11:0]);
			default: ;
		endcase
		// Only the top page is left: the banked echo, OAM and high RAM.
		if (a <= ADDR_ECHO_END) return WRAM_CELL0 + wb * WRAM_BANK_SIZE + int'(a[11:0]);
		if (a <= ADDR_OAM_END) return OAM_CELL0 + int'(a - OAM_BASE_ADDR);
		if (a >= ADDR_HRAM_BASE && a <= ADDR_HRAM_END)
			return HRAM_CELL0 + int'(a - ADDR_HRAM_BASE);
		return -1;
	endfunction

	function automatic bit readable(input logic [15:0] a);
		int c;
		c = cell_of(a);
		return c < 0 || mirror_written[c];
	endfunction

	function automatic logic [7:0] predict_read(input logic [15:0] a);
		int c;
		c = cell_of(a);
		if (a == ADDR_IRQ_EN) return irq_enable;
		if (c >= 0) return mirror_mem[c];
		if (a >= IO_BASE_ADDR && a <= ADDR_IO_END && io_mapped(a[6:0])) return io_regs[a[6:0]];
		return OPEN_BUS;
	endfunction

	function automatic void apply_write(input logic [15:0] a, input logic [7:0] d);
		int c;
		// There is no bank controller, so the whole ROM area ignores writes.
		if (a <= ADDR_ROM_END) return;
		if (a == ADDR_IRQ_EN) begin
			irq_enable = d;
			return;
		end
		c = cell_of(a);
		if (c >= 0) begin
			mirror_mem[c] = d;
			mirror_written[c] = 1'b1;
			return;
		end
		if (a < IO_BASE_ADDR || a > ADDR_IO_END) return;
		// The joypad and status registers only take the writable bits; the divider is
		// cleared whatever the data; unmapped offsets drop the write.
		if (a == JOYPAD_ADDR)
			io_regs[a[6:0]] = (io_regs[a[6:0]] & ~JOYP_MASK) | (d & JOYP_MASK);
		else if (a == STATUS_ADDR)
			io_regs[a[6:0]] = (io_regs[a[6:0]] & ~STAT_MASK) | (d & STAT_MASK);
		else if (a == DIVIDER_ADDR)
			io_regs[a[6:0]] = 8'h00;
		else if (io_mapped(a[6:0]))
			io_regs[a[6:0]] = d;
	endfunction

	// Updates the mirror for one accepted transaction and, for a read, queues the byte
	// that must come back.
	function automatic void apply_access(input op_t op, input logic [15:0] a,
			input logic [7:0] d, input logic [1:0] lb);
		pending_read_t pr;
		int c;
		case (op)
			OP_READ: begin
				pr.addr = a;
				pr.value = predict_read(a);
				pending_reads.push_back(pr);
			end
			OP_WRITE: apply_write(a, d);
			OP_LOAD_CART: begin
				c = CART_CELL0 + (int'(lb) % CART_ROM_BANKS_DEF) * ROM_BANK_SIZE
					+ int'(a[13:0]);
				mirror_mem[c] = d;
				mirror_written[c] = 1'b1;
			end
			OP_LOAD_BOOT: begin
				c = BOOT_CELL0 + int'(a[7:0]);
				mirror_mem[c] = d;
				mirror_written[c] = 1'b1;
			end
		endcase
	endfunction

	// Presents one transaction, possibly after random idle cycles, and holds it until
	// the block takes it. Each cycle ahead of the transaction is idle with the idle
	// percentage as its chance. Valid stays high on return so that back-to-back
	// transactions need no extra assignment in the same time step.
	task automatic issue_access(input op_t op, input logic [15:0] a, input logic [7:0] d,
			input logic [1:0] lb);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid   <= 1'b1;
		operation  <= op;
		address    <= a;
		write_data <= d;
		load_bank  <= lb;
		do @(posedge clk); while (!in_ready);
		apply_access(op, a, d, lb);
	endtask

	// Bank selects only change while the block is idle: the input side is parked, all
	// reads are back, and a short pause lets a trailing write finish.
	task automatic set_register(input cfg_idx_t idx, input logic [1:0] value);
		in_valid <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_BOOT_EN:   boot_en  = value[0];
			CFG_ROM_BANK:  rom_sel  = value;
			CFG_SRAM_BANK: sram_sel = value;
			CFG_WRAM_BANK: wram_sel = value[0];
		endcase
	endtask

	task automatic apply_settings(input logic boot, input logic [1:0] rom,
			input logic [1:0] sram, input logic wram);
		set_register(CFG_BOOT_EN, {1'b0, boot});
		set_register(CFG_ROM_BANK, rom);
		set_register(CFG_SRAM_BANK, sram);
		set_register(CFG_WRAM_BANK, {1'b0, wram});
	endtask

	// Records a written address; work RAM also records its echo alias.
	function automatic void remember(input logic [15:0] a);
		known_addrs.push_back(a);
		if (a >= 16'hC000 && a <= WRAM_HIGH_ADDR) known_addrs.push_back(a + 16'h2000);
		if (a >= 16'hE000 && a <= ADDR_ECHO_END) known_addrs.push_back(a - 16'h2000);
		while (known_addrs.size() > KNOWN_DEPTH) void'(known_addrs.pop_front());
	endfunction

	function automatic logic [15:0] io_register_addr();
		return IO_BASE_ADDR | 16'(IO_OFFSETS[$urandom_range(16)]);
	endfunction

	// Picks a remembered address that currently maps onto a written entry, favoring
	// recent writes; falls back to an I/O register, which is always defined.
	function automatic logic [15:0] choose_readable_addr();
		int k;
		int span;
		logic [15:0] a;
		for (int t = 0; t < 6; t++) begin
			if (known_addrs.size() == 0) break;
			span = (known_addrs.size() > 16) ? 16 : known_addrs.size();
			if ($urandom_range(1))
				k = $urandom_range(known_addrs.size() - 1);
			else
				k = known_addrs.size() - 1 - $urandom_range(span - 1);
			a = known_addrs[k];
			if (readable(a)) return a;
		end
		return io_register_addr();
	endfunction

	function automatic logic [15:0] random_ram_addr();
		if ($urandom_range(9) < 8) return 16'($urandom_range(ADDR_ECHO_END, VRAM_BASE_ADDR));
		if ($urandom_range(1)) return OAM_BASE_ADDR + 16'($urandom_range(OAM_SIZE - 1));
		return ADDR_HRAM_BASE + 16'($urandom_range(HRAM_SIZE - 1));
	endfunction

	// Registers right after reset, open bus on the unusable range and serial ports.
	task automatic test_reset_state();
		issue_access(OP_READ, JOYPAD_ADDR, 8'h00, 2'd0);
		issue_access(OP_READ, STATUS_ADDR, 8'h00, 2'd0);
		issue_access(OP_READ, DIVIDER_ADDR, 8'h00, 2'd0);
		issue_access(OP_READ, ADDR_IRQ_EN, 8'h00, 2'd0);
		issue_access(OP_READ, UNUSED_BASE_ADDR, 8'h00, 2'd0);
		issue_access(OP_READ, SERIAL_DATA_ADDR, 8'h00, 2'd0);
		issue_access(OP_READ, SERIAL_CTRL_ADDR, 8'h00, 2'd0);
	endtask

	// Masked joypad and status writes, the divider clear and an ignored write.
	task automatic test_io_write_rules();
		issue_access(OP_WRITE, JOYPAD_ADDR, 8'hFF, 2'd0);
		issue_access(OP_READ, JOYPAD_ADDR, 8'h00, 2'd0);
		issue_access(OP_WRITE, STATUS_ADDR, 8'hFF, 2'd0);
		issue_access(OP_READ, STATUS_ADDR, 8'h00, 2'd0);
		issue_access(OP_WRITE, DIVIDER_ADDR, 8'hA5, 2'd0);
		issue_access(OP_READ, DIVIDER_ADDR, 8'h00, 2'd0);
		issue_access(OP_WRITE, ADDR_UNUSED_END, 8'h12, 2'd0);
		issue_access(OP_READ, ADDR_UNUSED_END, 8'h00, 2'd0);
	endtask

	// Preload offsets drop the high address bits. The boot ROM shadows cartridge
	// byte zero until the overlay is switched off, and the ROM area drops writes.
	task automatic test_boot_overlay();
		issue_access(OP_LOAD_BOOT, 16'hFF00, 8'hA5, 2'd0);
		issue_access(OP_LOAD_CART, 16'hC000, 8'h5A, 2'd0);
		issue_access(OP_READ, 16'h0000, 8'h00, 2'd0);
		set_register(CFG_BOOT_EN, 2'd0);
		issue_access(OP_READ, 16'h0000, 8'h00, 2'd0);
		issue_access(OP_WRITE, 16'h0000, 8'h77, 2'd0);
		issue_access(OP_READ, 16'h0000, 8'h00, 2'd0);
	endtask

	// The top cartridge bank at its last offset, seen through the banked window.
	task automatic test_banked_rom();
		issue_access(OP_LOAD_CART, 16'hFFFF, 8'hC3, 2'd3);
		set_register(CFG_ROM_BANK, 2'd3);
		issue_access(OP_READ, ADDR_ROM_END, 8'h00, 2'd0);
	endtask

	// A write at the top of the echo read back at once through work RAM, which checks
	// that the store gives the byte just written to the very next read.
	task automatic test_echo_forwarding();
		issue_access(OP_WRITE, ADDR_ECHO_END, 8'h3C, 2'd0);
		issue_access(OP_READ, WRAM_HIGH_ADDR, 8'h00, 2'd0);
	endtask

	// Random traffic: writes and preloads, reads of what was stored, and beside them
	// I/O accesses, the interrupt enable, the unusable range and stray writes anywhere
	// on the bus.
	task automatic run_random_traffic(input int count);
		int r;
		logic [15:0] a;
		logic [1:0] lb;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 35) begin
				issue_access(OP_READ, choose_readable_addr(), 8'($urandom), 2'($urandom));
			end else if (r < 55) begin
				a = random_ram_addr();
				issue_access(OP_WRITE, a, 8'($urandom), 2'($urandom));
				remember(a);
			end else if (r < 65) begin
				a = 16'($urandom);
				lb = 2'($urandom);
				issue_access(OP_LOAD_CART, a, 8'($urandom), lb);
				if (lb == 2'd0) remember({2'b00, a[13:0]});
				remember({2'b01, a[13:0]});
			end else if (r < 70) begin
				a = 16'($urandom);
				issue_access(OP_LOAD_BOOT, a, 8'($urandom), 2'($urandom));
				remember({8'h00, a[7:0]});
			end else if (r < 85) begin
				// Mostly real registers, sometimes any offset in the I/O page.
				a = ($urandom_range(9) < 7) ? io_register_addr()
					: IO_BASE_ADDR | 16'($urandom_range(127));
				issue_access($urandom_range(1) ? OP_READ : OP_WRITE, a, 8'($urandom),
					2'($urandom));
			end else if (r < 92) begin
				a = $urandom_range(1) ? ADDR_IRQ_EN
					: UNUSED_BASE_ADDR + 16'($urandom_range(ADDR_UNUSED_END - UNUSED_BASE_ADDR));
				issue_access($urandom_range(1) ? OP_READ : OP_WRITE, a, 8'($urandom),
					2'($urandom));
			end else begin
				issue_access(OP_WRITE, 16'($urandom), 8'($urandom), 2'($urandom));
			end
		end
	endtask

	// Five phases of random traffic under different bank settings: all zero, all at
	// their top values with no idling on either side, then three random settings.
	task automatic test_random_phases();
		apply_settings(1'b0, 2'd0, 2'd0, 1'b0);
		run_random_traffic(PHASE_ITEMS);
		apply_settings(1'b1, 2'd3, 2'd3, 1'b1);
		steady = 1'b1;
		run_random_traffic(PHASE_ITEMS);
		steady = 1'b0;
		repeat (3) begin
			apply_settings(1'($urandom), 2'($urandom), 2'($urandom), 1'($urandom));
			run_random_traffic(PHASE_ITEMS);
		end
	endtask

	// The receiver stalls at random except during the steady phase.
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// Each returned byte is checked against the oldest outstanding read.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_reads.size() == 0) begin
				report_mismatch($sformatf("read data 0x%02h with no read outstanding",
					read_data));
			end else begin
				head_read = pending_reads.pop_front();
				if (read_data !== head_read.value)
					report_mismatch($sformatf("read of 0x%04h gave 0x%02h, want 0x%02h",
						head_read.addr, read_data, head_read.value));
			end
		end
	end

	// Ends the run when no transaction of any kind has moved for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		foreach (io_regs[k]) io_regs[k] = 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_io_write_rules();
		test_boot_overlay();
		test_banked_rom();
		test_echo_forwarding();
		test_random_phases();

		// Park the input side, collect every outstanding read, then give the block
		// time to show any result that should not be there.
		in_valid <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
